// File: hw/rtl/pct_pkg.sv
package pct_pkg;

    localparam int FUNC_W      = 2;
    localparam int KEY_W       = 48;
    localparam int GEN_W       = 64;
    localparam int TIME_W      = 64;
    localparam int CD_W        = 32;
    localparam int ALU_W       = 64;
    localparam int ENTRIES_DEF = 16;

    localparam logic [CD_W-1:0] COOLDOWN_RST = CD_W'(1000);

    localparam logic [FUNC_W-1:0] FN_ACQUIRE = 2'd0;
    localparam logic [FUNC_W-1:0] FN_KEEP    = 2'd1;
    localparam logic [FUNC_W-1:0] FN_SWEEP   = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic              scope;
        logic [GEN_W-1:0]  gen;
        logic [TIME_W-1:0] deadline;
    } t_entry;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        logic    en;
        t_alu_op op;
    } t_alu_ctl;

endpackage

// File: hw/rtl/pct_if.sv
interface pct_req_if import pct_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  dest_key;
    logic              scope;
    logic [GEN_W-1:0]  generation;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, func, dest_key, scope, generation, now_ms, input ready);
    modport sink   (input valid, func, dest_key, scope, generation, now_ms, output ready);
endinterface

interface pct_rsp_if;
    logic valid;
    logic ready;
    logic granted;
    logic table_full;

    modport source (output valid, granted, table_full, input ready);
    modport sink   (input valid, granted, table_full, output ready);
endinterface

// File: hw/rtl/pct_alu.sv
module pct_alu
    import pct_pkg::*;
(
    input  logic             i_clk,
    input  t_alu_ctl         i_ctl,
    input  logic [ALU_W-1:0] i_a,
    input  logic [ALU_W-1:0] i_b,
    output logic [ALU_W-1:0] o_res,
    output logic             o_borrow
);

    logic [ALU_W-1:0] r_res;
    logic             r_borrow;
    logic             sub;
    logic [ALU_W-1:0] b_eff;
    logic [ALU_W:0]   sum;

    assign sub   = (i_ctl.op == ALU_SUB);
    assign b_eff = sub ? ~i_b : i_b;
    assign sum   = {1'b0, i_a} + {1'b0, b_eff} + {{ALU_W{1'b0}}, sub};

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_res    <= sum[ALU_W-1:0];
            // carry out of a - b is set when no borrow occurred
            r_borrow <= ~sum[ALU_W];
        end
    end

    assign o_res    = r_res;
    assign o_borrow = r_borrow;

endmodule

// File: hw/rtl/pct_mem.sv
module pct_mem
    import pct_pkg::*;
#(
    parameter int DEPTH = ENTRIES_DEF,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/probe_cooldown_table.sv
// Per-destination probe cooldown table. Each request (acquire, keep mark,
// sweep or the unused function code) is taken as one transaction on i_req and
// answered by exactly one transaction on o_rsp. Acquire with a nonzero key
// and keep mark scan the entry memory one entry per cycle through its single
// registered read port. Generation compare, deadline test and the new
// deadline then go through one shared 64-bit add/subtract unit in successive
// cycles. After the scan and S_DRAIN, S_DEC ends a keep mark or an insert
// refused on a full table in S_FIN; an insert goes through S_WR, a hit that
// is denied through S_GEN and S_CHK, and a hit that is granted through S_GEN,
// S_CHK and S_WR. S_FIN loads the result into the output register. A sweep,
// an acquire with a zero key or the unused code goes from S_IDLE straight to
// S_FIN. i_req.ready is high only while no request is in progress, so the
// next request is accepted in the cycle after the result is loaded at the
// earliest. The output register lets it in while o_rsp waits; its own result
// then holds until o_rsp is taken. When no entry is free an insert is refused
// with table_full set. Write the cooldown interval through
// i_cfg_we/i_cfg_wdata only while the block is idle.
module probe_cooldown_table
    import pct_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [CD_W-1:0] i_cfg_wdata,
    pct_req_if.sink         i_req,
    pct_rsp_if.source       o_rsp
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DEC,
        S_GEN,
        S_CHK,
        S_WR,
        S_FIN
    } t_state;

    t_state              r_state,   n_state;
    logic [IDX_W-1:0]    r_idx,     n_idx;
    logic                r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]    r_cmp_idx, n_cmp_idx;
    logic [FUNC_W-1:0]   r_func,    n_func;
    logic [KEY_W-1:0]    r_key,     n_key;
    logic                r_scope,   n_scope;
    logic [GEN_W-1:0]    r_gen,     n_gen;
    logic [TIME_W-1:0]   r_now,     n_now;
    logic [CD_W-1:0]     r_cooldown, n_cooldown;
    logic [ENTRIES-1:0]  r_valid,   n_valid;
    logic [ENTRIES-1:0]  r_keep,    n_keep;
    logic                r_hit,     n_hit;
    logic [IDX_W-1:0]    r_hit_idx, n_hit_idx;
    logic                r_free,    n_free;
    logic [IDX_W-1:0]    r_free_idx, n_free_idx;
    logic [GEN_W-1:0]    r_ent_gen, n_ent_gen;
    logic [TIME_W-1:0]   r_ent_dl,  n_ent_dl;
    logic                r_older,   n_older;
    logic                r_same,    n_same;
    logic                r_res_g,   n_res_g;
    logic                r_res_f,   n_res_f;
    logic                r_out_vld, n_out_vld;
    logic                r_out_g,   n_out_g;
    logic                r_out_f,   n_out_f;

    t_alu_ctl            alu_ctl;
    logic [ALU_W-1:0]    alu_a;
    logic [ALU_W-1:0]    alu_b;
    logic [ALU_W-1:0]    alu_res;
    logic                alu_borrow;

    logic                mem_we;
    logic [IDX_W-1:0]    wr_idx;
    t_entry              mem_wdata;
    t_entry              mem_rdata;

    pct_alu u_alu (
        .i_clk    (i_clk),
        .i_ctl    (alu_ctl),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_res    (alu_res),
        .o_borrow (alu_borrow)
    );

    pct_mem #(
        .DEPTH (ENTRIES),
        .AW    (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (wr_idx),
        .i_wdata (mem_wdata),
        .i_raddr (r_idx),
        .o_rdata (mem_rdata)
    );

    assign wr_idx    = r_hit ? r_hit_idx : r_free_idx;
    assign mem_wdata = '{key: r_key, scope: r_scope, gen: r_gen, deadline: alu_res};

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.granted    = r_out_g;
    assign o_rsp.table_full = r_out_f;

    always_comb begin
        logic ent_v;
        logic key_eq;
        logic scope_ok;
        logic supp;

        n_state    = r_state;
        n_idx      = r_idx;
        n_cmp_vld  = (r_state == S_SCAN);
        n_cmp_idx  = r_idx;
        n_func     = r_func;
        n_key      = r_key;
        n_scope    = r_scope;
        n_gen      = r_gen;
        n_now      = r_now;
        n_cooldown = i_cfg_we ? i_cfg_wdata : r_cooldown;
        n_valid    = r_valid;
        n_keep     = r_keep;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_free     = r_free;
        n_free_idx = r_free_idx;
        n_ent_gen  = r_ent_gen;
        n_ent_dl   = r_ent_dl;
        n_older    = r_older;
        n_same     = r_same;
        n_res_g    = r_res_g;
        n_res_f    = r_res_f;
        n_out_vld  = r_out_vld;
        n_out_g    = r_out_g;
        n_out_f    = r_out_f;

        alu_ctl    = '{en: 1'b0, op: ALU_ADD};
        alu_a      = r_now;
        alu_b      = ALU_W'(r_cooldown);
        mem_we     = 1'b0;

        // compare stage: entry read last cycle is on mem_rdata
        ent_v    = r_valid[r_cmp_idx];
        key_eq   = (mem_rdata.key == r_key);
        scope_ok = (mem_rdata.scope == r_scope);
        supp     = 1'b0;
        if (r_cmp_vld) begin
            if (r_func == FN_KEEP) begin
                if (ent_v && key_eq) begin
                    n_keep[r_cmp_idx] = 1'b1;
                end
            end else begin
                if (ent_v && key_eq && scope_ok && !r_hit) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_cmp_idx;
                    n_ent_gen = mem_rdata.gen;
                    n_ent_dl  = mem_rdata.deadline;
                end
                if (!ent_v && !r_free) begin
                    n_free     = 1'b1;
                    n_free_idx = r_cmp_idx;
                end
            end
        end

        if (r_out_vld && o_rsp.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_func  = i_req.func;
                    n_key   = i_req.dest_key;
                    n_scope = i_req.scope;
                    n_gen   = i_req.generation;
                    n_now   = i_req.now_ms;
                    n_idx   = '0;
                    n_hit   = 1'b0;
                    n_free  = 1'b0;
                    n_res_g = 1'b0;
                    n_res_f = 1'b0;
                    case (i_req.func)
                        FN_ACQUIRE: begin
                            n_state = (i_req.dest_key == '0) ? S_FIN : S_SCAN;
                        end
                        FN_KEEP: begin
                            n_state = S_SCAN;
                        end
                        FN_SWEEP: begin
                            n_valid = r_valid & r_keep;
                            n_keep  = '0;
                            n_state = S_FIN;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_DEC;
            end
            S_DEC: begin
                if (r_func == FN_KEEP) begin
                    n_state = S_FIN;
                end else if (r_hit) begin
                    alu_ctl = '{en: 1'b1, op: ALU_SUB};
                    alu_a   = r_gen;
                    alu_b   = r_ent_gen;
                    n_state = S_GEN;
                end else if (r_free) begin
                    alu_ctl = '{en: 1'b1, op: ALU_ADD};
                    n_state = S_WR;
                end else begin
                    n_res_f = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_GEN: begin
                n_older = alu_borrow;
                n_same  = (alu_res == '0);
                // remaining time until the stored deadline
                alu_ctl = '{en: 1'b1, op: ALU_SUB};
                alu_a   = r_ent_dl;
                alu_b   = r_now;
                n_state = S_CHK;
            end
            S_CHK: begin
                supp = r_same && (alu_res != '0) && !alu_res[ALU_W-1];
                if (r_older || supp) begin
                    n_state = S_FIN;
                end else begin
                    alu_ctl = '{en: 1'b1, op: ALU_ADD};
                    n_state = S_WR;
                end
            end
            S_WR: begin
                mem_we          = 1'b1;
                n_valid[wr_idx] = 1'b1;
                if (!r_hit) begin
                    n_keep[wr_idx] = 1'b0;
                end
                n_res_g = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                // hold the result until the output register is free
                if (!r_out_vld || o_rsp.ready) begin
                    n_out_vld = 1'b1;
                    n_out_g   = r_res_g;
                    n_out_f   = r_res_f;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_cmp_idx  <= n_cmp_idx;
        r_func     <= n_func;
        r_key      <= n_key;
        r_scope    <= n_scope;
        r_gen      <= n_gen;
        r_now      <= n_now;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_free     <= n_free;
        r_free_idx <= n_free_idx;
        r_ent_gen  <= n_ent_gen;
        r_ent_dl   <= n_ent_dl;
        r_older    <= n_older;
        r_same     <= n_same;
        r_res_g    <= n_res_g;
        r_res_f    <= n_res_f;
        r_out_g    <= n_out_g;
        r_out_f    <= n_out_f;
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cmp_vld  <= 1'b0;
            r_cooldown <= COOLDOWN_RST;
            r_valid    <= '0;
            r_keep     <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cmp_vld  <= n_cmp_vld;
            r_cooldown <= n_cooldown;
            r_valid    <= n_valid;
            r_keep     <= n_keep;
            r_out_vld  <= n_out_vld;
        end
    end

endmodule

// File: hw/rtl/pct_chk.sv
module pct_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input logic i_granted,
    input logic i_table_full
);

    // the block works on one request at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request accepted while a request was in progress");

    a_grant_excl_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !(i_granted && i_table_full))
        else $error("granted and table_full both set");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_granted) && $stable(i_table_full)))
        else $error("stalled response changed");

    // a new response only comes out of a request in progress
    a_rsp_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |-> $past(!i_req_ready))
        else $error("response without a request in progress");

endmodule

bind probe_cooldown_table pct_chk u_pct_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_granted    (o_rsp.granted),
    .i_table_full (o_rsp.table_full)
);
